[rtl/ps2mct_pkg.sv]
package ps2mct_pkg;

   // Coordinate width of the cursor position
   localparam int COORD_BITS_DEFAULT = 13;

   // Screen size register width and reset values
   localparam int REG_W = 14;
   localparam logic [REG_W-1:0] WIDTH_RESET  = 14'd1024;
   localparam logic [REG_W-1:0] HEIGHT_RESET = 14'd768;

   // Register indexes, decoded from paddr[2]
   localparam logic CSR_WIDTH_IDX  = 1'b0;
   localparam logic CSR_HEIGHT_IDX = 1'b1;
   localparam int   PADDR_W        = 3;

   // Packet byte phase
   localparam logic [1:0] PHASE_FLAG = 2'd0;
   localparam logic [1:0] PHASE_X    = 2'd1;
   localparam logic [1:0] PHASE_Y    = 2'd2;

   // Bit positions in the flag byte
   localparam int FLAG_SYNC_BIT  = 3;
   localparam int FLAG_XSIGN_BIT = 4;
   localparam int FLAG_YSIGN_BIT = 5;
   localparam int FLAG_XOVER_BIT = 6;
   localparam int FLAG_YOVER_BIT = 7;

   // Signed movement of one axis: 9-bit two's complement plus overflow
   function automatic logic signed [10:0] axis_move(input logic [7:0] b,
                                                    input logic neg,
                                                    input logic over);
      logic [9:0] mag;
      mag = neg ? (10'd256 - {2'b00, b}) : {2'b00, b};
      if (over) begin
         mag = mag + 10'd255;
      end
      return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

[rtl/ps2_mouse_cursor_tracker_core.sv]
// PS/2 mouse cursor tracker.
//
// req channel: one received mouse byte per transfer (req_rx_byte). A packet
// starts with a flag byte that has bit 3 set; bytes without it are dropped
// while waiting. The next two bytes are the X and Y movement.
// rsp channel: after the Y byte the cursor is moved, clamped to the screen
// and presented as one transfer (rsp_cursor_x, rsp_cursor_y), registered in the
// cycle after the Y byte is taken. Flag and X bytes give no result.
// Throughput: one byte per cycle while req_stall is low; decode and clamp sit between the byte
// input and the position register, which is also the result register.
// While a result waits under rsp_stall, req_stall is raised, so input is
// held until the result is taken.
// APB port: register 0 (address 0) screen width, register 1 (address 4)
// screen height, 14 bits each; write only while the block is idle.
// Reset (synchronous): width 1024, height 768, cursor at 0,0, waiting for a
// flag byte, no result pending.
module ps2_mouse_cursor_tracker_core #(
   parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [COORD_BITS-1:0]            rsp_cursor_x,
   output logic [COORD_BITS-1:0]            rsp_cursor_y,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ps2mct_pkg::PADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import ps2mct_pkg::*;

   localparam int SumW = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 2;

   logic [REG_W-1:0]      width_ff, height_ff;
   logic [1:0]            phase_ff, phase_in;
   logic [7:0]            flag_ff, flag_in;
   logic [7:0]            xmove_ff, xmove_in;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_take;
   logic                  csr_write;
   logic                  packet_done;
   logic signed [10:0]    dx, dy;
   logic signed [SumW-1:0] nx, ny;

   function automatic logic [COORD_BITS-1:0] clamp_axis(input logic signed [SumW-1:0] v,
                                                        input logic [REG_W-1:0] extent);
      logic [SumW-1:0] lim;
      logic [SumW-1:0] cmax;
      logic [SumW-1:0] res;
      cmax = {{(SumW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
      lim  = (extent == '0) ? '0 : (SumW'(extent) - SumW'(1));
      if (lim > cmax) begin
         lim = cmax;
      end
      if (v < 0) begin
         res = '0;
      end else if ($unsigned(v) > lim) begin
         res = lim;
      end else begin
         res = $unsigned(v);
      end
      return res[COORD_BITS-1:0];
   endfunction

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign prdata    = (paddr[2] == CSR_HEIGHT_IDX) ? {18'd0, height_ff} : {18'd0, width_ff};

   // Hold input while a result waits to be taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   assign packet_done = req_take & (phase_ff == PHASE_Y);

   assign dx = axis_move(xmove_ff, flag_ff[FLAG_XSIGN_BIT], flag_ff[FLAG_XOVER_BIT]);
   assign dy = axis_move(req_rx_byte, flag_ff[FLAG_YSIGN_BIT], flag_ff[FLAG_YOVER_BIT]);
   assign nx = $signed({{(SumW-COORD_BITS){1'b0}}, pos_x_ff}) + SumW'(dx);
   assign ny = $signed({{(SumW-COORD_BITS){1'b0}}, pos_y_ff}) - SumW'(dy);

   always_comb begin
      phase_in     = phase_ff;
      flag_in      = flag_ff;
      xmove_in     = xmove_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_take) begin
         unique case (phase_ff)
            PHASE_X: begin
               xmove_in = req_rx_byte;
               phase_in = PHASE_Y;
            end
            PHASE_Y: begin
               phase_in     = PHASE_FLAG;
               pos_x_in     = clamp_axis(nx, width_ff);
               pos_y_in     = clamp_axis(ny, height_ff);
               rsp_valid_in = 1'b1;
            end
            default: begin
               // Drop bytes until one carries the sync bit
               phase_in = PHASE_FLAG;
               if (req_rx_byte[FLAG_SYNC_BIT]) begin
                  flag_in  = req_rx_byte;
                  phase_in = PHASE_X;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         phase_ff     <= PHASE_FLAG;
         flag_ff      <= '0;
         xmove_ff     <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         flag_ff      <= flag_in;
         xmove_ff     <= xmove_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            if (paddr[2] == CSR_HEIGHT_IDX) begin
               height_ff <= pwdata[REG_W-1:0];
            end else begin
               width_ff <= pwdata[REG_W-1:0];
            end
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cursor_x = pos_x_ff;
   assign rsp_cursor_y = pos_y_ff;

`ifndef ASSERT_OFF
   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      packet_done |=> rsp_valid_ff)
      else $error("completed packet did not raise a result");

   a_taken_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !packet_done) |=> !rsp_valid_ff)
      else $error("result stayed valid after transfer");

   a_nosync_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_take && phase_ff == PHASE_FLAG && !req_rx_byte[FLAG_SYNC_BIT])
      |=> (phase_ff == PHASE_FLAG && $stable(flag_ff)))
      else $error("byte without sync bit started a packet");

   a_idle_phase_no_move: assert property (@(posedge clock) disable iff (reset)
      (req_take && phase_ff != PHASE_Y) |=> ($stable(pos_x_ff) && $stable(pos_y_ff)))
      else $error("cursor moved before the packet was complete");
`endif

endmodule

[bench/ps2mct_cursor_scoreboard.sv]
module ps2mct_cursor_scoreboard #(
   parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [7:0]                     req_rx_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [COORD_BITS-1:0]          rsp_cursor_x,
   input  logic [COORD_BITS-1:0]          rsp_cursor_y,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [ps2mct_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output int                             fail_count,
   output int                             pending
);
   import ps2mct_pkg::*;

   localparam int COORD_MAX = (1 << COORD_BITS) - 1;
   localparam logic [PADDR_W-1:0] ADDR_WIDTH  = PADDR_W'(0);
   localparam logic [PADDR_W-1:0] ADDR_HEIGHT = PADDR_W'(4);

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } cursor_type;

   cursor_type           cursor_q[$];
   logic [1:0]           phase;
   logic [7:0]           flags;
   logic [7:0]           x_byte;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   logic [REG_W-1:0]     width;
   logic [REG_W-1:0]     height;

   // Signed move of one axis: sign flag widens the byte to nine bits
   function automatic int move_of(input logic [7:0] b, input logic neg, input logic over);
      int size;
      size = neg ? 256 - int'(b) : int'(b);
      if (over) begin
         size = size + 255;
      end
      return neg ? -size : size;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_to(input int v,
                                                      input logic [REG_W-1:0] extent);
      int lim;
      lim = (extent == '0) ? 0 : int'(extent) - 1;
      if (lim > COORD_MAX) begin
         lim = COORD_MAX;
      end
      if (v < 0) begin
         return '0;
      end
      if (v > lim) begin
         return COORD_BITS'(lim);
      end
      return COORD_BITS'(v);
   endfunction

   task automatic track_byte(input logic [7:0] b);
      int         nx;
      int         ny;
      cursor_type c;
      case (phase)
         PHASE_X: begin
            x_byte = b;
            phase  = PHASE_Y;
         end
         PHASE_Y: begin
            phase = PHASE_FLAG;
            nx = int'(pos_x) + move_of(x_byte, flags[FLAG_XSIGN_BIT], flags[FLAG_XOVER_BIT]);
            ny = int'(pos_y) - move_of(b, flags[FLAG_YSIGN_BIT], flags[FLAG_YOVER_BIT]);
            pos_x = clamp_to(nx, width);
            pos_y = clamp_to(ny, height);
            c.x = pos_x;
            c.y = pos_y;
            cursor_q.push_back(c);
         end
         default: begin
            // drop bytes that cannot start a packet
            phase = PHASE_FLAG;
            if (b[FLAG_SYNC_BIT]) begin
               flags = b;
               phase = PHASE_X;
            end
         end
      endcase
   endtask

   task automatic report(input string what, input cursor_type want, input cursor_type got);
      fail_count = fail_count + 1;
      if (fail_count <= 10) begin
         $display("%0t cursor mismatch (%s): expected x=%0d y=%0d, got x=%0d y=%0d",
                  $realtime, what, want.x, want.y, got.x, got.y);
      end
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      cursor_type got;
      cursor_type want;
      if (reset) begin
         cursor_q.delete();
         phase  = PHASE_FLAG;
         flags  = '0;
         x_byte = '0;
         pos_x  = '0;
         pos_y  = '0;
         width  = WIDTH_RESET;
         height = HEIGHT_RESET;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_WIDTH) begin
               width = pwdata[REG_W-1:0];
            end else if (paddr == ADDR_HEIGHT) begin
               height = pwdata[REG_W-1:0];
            end
         end
         if (req_valid && !req_stall) begin
            track_byte(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            got.x = rsp_cursor_x;
            got.y = rsp_cursor_y;
            if (cursor_q.size() == 0) begin
               want = '0;
               report("unexpected transfer", want, got);
            end else begin
               want = cursor_q.pop_front();
               if (got.x !== want.x) begin
                  report("cursor_x", want, got);
               end else if (got.y !== want.y) begin
                  report("cursor_y", want, got);
               end
            end
         end
      end
      pending = cursor_q.size();
   end

endmodule

[bench/tb_ps2_mouse_cursor_tracker_core.sv]
module tb_ps2_mouse_cursor_tracker_core;
   import ps2mct_pkg::*;

   localparam int CB = COORD_BITS_DEFAULT;
   localparam logic [PADDR_W-1:0] ADDR_WIDTH  = PADDR_W'(0);
   localparam logic [PADDR_W-1:0] ADDR_HEIGHT = PADDR_W'(4);
   localparam int N_SETTINGS = 7;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic [CB-1:0]        rsp_cursor_x;
   logic [CB-1:0]        rsp_cursor_y;
   logic                 psel        = 1'b0;
   logic                 penable     = 1'b0;
   logic                 pwrite      = 1'b0;
   logic [PADDR_W-1:0]   paddr       = '0;
   logic [31:0]          pwdata      = '0;
   logic [31:0]          prdata;
   logic                 pready;
   logic                 quiet       = 1'b0;
   int                   fail_count;
   int                   pending;

   logic [REG_W-1:0] width_set  [N_SETTINGS] = '{14'd16383, 14'd1, 14'd8192, 14'd0,
                                                  14'd640, 14'd100, 14'd1024};
   logic [REG_W-1:0] height_set [N_SETTINGS] = '{14'd0, 14'd1, 14'd8192, 14'd16383,
                                                  14'd480, 14'd50, 14'd768};

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   ps2_mouse_cursor_tracker_core #(.COORD_BITS(CB)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cursor_x(rsp_cursor_x), .rsp_cursor_y(rsp_cursor_y),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   ps2mct_cursor_scoreboard #(.COORD_BITS(CB)) u_scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cursor_x(rsp_cursor_x), .rsp_cursor_y(rsp_cursor_y),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 7);
   end

   task automatic send_byte(input logic [7:0] b);
      while (!quiet && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_packet(input logic [7:0] f, input logic [7:0] dx, input logic [7:0] dy);
      send_byte(f);
      send_byte(dx);
      send_byte(dy);
   endtask

   // hold the sender until every cursor transfer is in, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [REG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      // upper bits carry junk; only the low register bits count
      pwdata  <= ($urandom & ~32'h3FFF) | 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_stream(input int n);
      int         sent;
      logic [7:0] f;
      sent = 0;
      while (sent < n) begin
         f    = 8'($urandom);
         f[FLAG_SYNC_BIT]  = 1'b1;
         f[FLAG_XOVER_BIT] = ($urandom_range(4) == 0);
         f[FLAG_YOVER_BIT] = ($urandom_range(4) == 0);
         case ($urandom_range(19))
            0, 1: begin
               send_byte(8'($urandom));
               sent = sent + 1;
            end
            2: begin
               // truncated packet: the next byte sent lands in the Y slot
               send_byte(f);
               send_byte(8'($urandom));
               sent = sent + 2;
            end
            default: begin
               send_packet(f, 8'($urandom), 8'($urandom));
               sent = sent + 3;
            end
         endcase
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset screen of 1024 by 768
      send_packet(8'h08, 8'h00, 8'h00);
      send_byte(8'h00);
      send_byte(8'hF7);
      send_packet(8'h08, 8'hFF, 8'h00);
      send_packet(8'h48, 8'hFF, 8'h00);
      send_packet(8'h48, 8'hFF, 8'hFF);
      send_packet(8'h18, 8'h00, 8'h00);
      send_packet(8'hA8, 8'h00, 8'h00);
      send_packet(8'h78, 8'h01, 8'h01);
      send_packet(8'hF8, 8'h00, 8'h80);

      for (int s = 0; s < N_SETTINGS; s++) begin
         settle();
         write_reg(ADDR_WIDTH, width_set[s]);
         write_reg(ADDR_HEIGHT, height_set[s]);
         if (s == 3) begin
            quiet <= 1'b1;
         end
         random_stream(72);
         if (s == 3) begin
            quiet <= 1'b0;
         end
      end

      settle();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
